>>> rtl/pc_pkg.sv
// Shared constants, types and sequencer codes of the Pearson correlation block.
package pc_pkg;

    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned MAX_SAMPLES = 1024;
    localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SUM_W       = SAMPLE_BITS + CNT_W - 1;
    localparam int unsigned SUM_EXT_W   = SUM_W + 1;
    localparam int unsigned SUM_XY_W    = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int unsigned SUM_SQ_W    = 2 * SAMPLE_BITS + CNT_W - 2;
    localparam int unsigned PROD_W      = 2 * SAMPLE_BITS;

    localparam int unsigned CORR_W        = 16;
    localparam int unsigned ALU_W         = 64;
    localparam int unsigned MUL_B_W       = 32;
    localparam int unsigned ROOT_W        = 32;
    localparam int unsigned ROOT_SHIFT    = 12;
    localparam int unsigned VAR_LIMIT_BIT = 50;
    localparam int unsigned QUO_W         = CORR_W + 1;
    localparam int unsigned DIV_STEPS     = QUO_W;
    localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam int unsigned PRE_SHIFT     = 28 - DIV_STEPS;

    localparam logic [QUO_W-1:0] ROUND_SAT = QUO_W'(1) << CORR_W;
    localparam logic [QUO_W-1:0] POS_MAX   = (QUO_W'(1) << (CORR_W - 1)) - QUO_W'(1);
    localparam logic [QUO_W-1:0] NEG_MAX   = QUO_W'(1) << (CORR_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_DIFF,
        S_CHECK,
        S_ROOT,
        S_ABS,
        S_PRE,
        S_DIV,
        S_DONE
    } eng_state_t;

    typedef enum logic [1:0] {
        MOP_NUM,
        MOP_VX,
        MOP_VY,
        MOP_DEN
    } mul_op_t;

    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [SUM_W-1:0]    sum_x;
        logic [SUM_W-1:0]    sum_y;
        logic [SUM_XY_W-1:0] sum_xy;
        logic [SUM_SQ_W-1:0] sum_xx;
        logic [SUM_SQ_W-1:0] sum_yy;
    } pc_sums_t;

    typedef struct packed {
        logic start;
        logic res_free;
    } pc_ctrl_t;

    typedef struct packed {
        logic              idle;
        logic              done;
        logic [CORR_W-1:0] correlation;
        logic              zero_variance;
    } pc_stat_t;

endpackage

>>> rtl/pc_if.sv
// Valid/ready channels for sample pairs and correlation results.
interface pc_in_if import pc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] x_sample;
    logic signed [SAMPLE_BITS-1:0] y_sample;
    logic                          last_pair;

    modport source (output valid, output x_sample, output y_sample, output last_pair,
                    input ready);
    modport sink (input valid, input x_sample, input y_sample, input last_pair,
                  output ready);
endinterface

interface pc_out_if import pc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [CORR_W-1:0] correlation;
    logic                     zero_variance;
    logic                     too_many_samples;
    logic [CNT_W-1:0]         pair_count;

    modport source (output valid, output correlation, output zero_variance,
                    output too_many_samples, output pair_count, input ready);
    modport sink (input valid, input correlation, input zero_variance,
                  input too_many_samples, input pair_count, output ready);
endinterface

>>> rtl/pearson_correlation.sv
// Streaming Pearson correlation of paired samples, result in Q1.15.
// A pair without the last mark is taken while the engine is idle, one pair per cycle.
// A last pair starts a sequence on one shared 64-bit adder: six shift-add products and, if
// no variance is zero, two 32-step square roots, one more product and, unless saturating, a
// 17-step division. The result loads once the output is free; no pair is taken meanwhile.
// Reset clears the count, all sums, the overflow flag and the pending result at once.
module pearson_correlation import pc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pc_in_if.sink     samples,
    pc_out_if.source  result
);

    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]    sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]    sum_y_reg, sum_y_next;
    logic signed [SUM_XY_W-1:0] sum_xy_reg, sum_xy_next;
    logic [SUM_SQ_W-1:0]        sum_xx_reg, sum_xx_next;
    logic [SUM_SQ_W-1:0]        sum_yy_reg, sum_yy_next;
    logic                       overflow_reg, overflow_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [CORR_W-1:0]   corr_reg, corr_next;
    logic                       zero_var_reg, zero_var_next;
    logic                       too_many_reg, too_many_next;
    logic [CNT_W-1:0]           pair_cnt_reg, pair_cnt_next;

    logic signed [PROD_W-1:0]   prod_xy, prod_xx, prod_yy;
    logic                       accept, out_free, load_result;

    pc_ctrl_t eng_ctrl;
    pc_sums_t eng_sums;
    pc_stat_t eng_stat;

    pc_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (eng_ctrl),
        .sums  (eng_sums),
        .stat  (eng_stat)
    );

    assign samples.ready = eng_stat.idle;
    assign accept        = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || result.ready;
    assign load_result   = eng_stat.done && out_free;

    assign eng_ctrl.start    = accept && samples.last_pair;
    assign eng_ctrl.res_free = out_free;

    assign eng_sums.count  = count_reg;
    assign eng_sums.sum_x  = sum_x_reg;
    assign eng_sums.sum_y  = sum_y_reg;
    assign eng_sums.sum_xy = sum_xy_reg;
    assign eng_sums.sum_xx = sum_xx_reg;
    assign eng_sums.sum_yy = sum_yy_reg;

    assign prod_xy = samples.x_sample * samples.y_sample;
    assign prod_xx = samples.x_sample * samples.x_sample;
    assign prod_yy = samples.y_sample * samples.y_sample;

    always_comb
    begin
        count_next    = count_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        sum_xy_next   = sum_xy_reg;
        sum_xx_next   = sum_xx_reg;
        sum_yy_next   = sum_yy_reg;
        overflow_next = overflow_reg;

        if (load_result)
        begin
            count_next    = '0;
            sum_x_next    = '0;
            sum_y_next    = '0;
            sum_xy_next   = '0;
            sum_xx_next   = '0;
            sum_yy_next   = '0;
            overflow_next = 1'b0;
        end
        else if (accept)
        begin
            // Once the count is full, further pairs only raise the overflow flag.
            if (count_reg == CNT_W'(MAX_SAMPLES))
                overflow_next = 1'b1;
            else
            begin
                count_next  = count_reg + CNT_W'(1);
                sum_x_next  = sum_x_reg + SUM_W'(samples.x_sample);
                sum_y_next  = sum_y_reg + SUM_W'(samples.y_sample);
                sum_xy_next = sum_xy_reg + SUM_XY_W'(prod_xy);
                sum_xx_next = sum_xx_reg + SUM_SQ_W'($unsigned(prod_xx));
                sum_yy_next = sum_yy_reg + SUM_SQ_W'($unsigned(prod_yy));
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        corr_next      = corr_reg;
        zero_var_next  = zero_var_reg;
        too_many_next  = too_many_reg;
        pair_cnt_next  = pair_cnt_reg;

        if (load_result)
        begin
            out_valid_next = 1'b1;
            corr_next      = eng_stat.correlation;
            zero_var_next  = eng_stat.zero_variance;
            too_many_next  = overflow_reg;
            pair_cnt_next  = count_reg;
        end
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    assign result.valid            = out_valid_reg;
    assign result.correlation      = corr_reg;
    assign result.zero_variance    = zero_var_reg;
    assign result.too_many_samples = too_many_reg;
    assign result.pair_count       = pair_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_xy_reg    <= '0;
            sum_xx_reg    <= '0;
            sum_yy_reg    <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_xy_reg    <= sum_xy_next;
            sum_xx_reg    <= sum_xx_next;
            sum_yy_reg    <= sum_yy_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        corr_reg     <= corr_next;
        zero_var_reg <= zero_var_next;
        too_many_reg <= too_many_next;
        pair_cnt_reg <= pair_cnt_next;
    end

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (count_reg == CNT_W'(MAX_SAMPLES)))
        else $error("overflow flagged before the count was full");

    a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (result.valid && count_reg == '0 && !overflow_reg))
        else $error("sums not cleared when the result was loaded");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && samples.last_pair) |=> !samples.ready)
        else $error("new request taken while the result is being computed");

endmodule

>>> rtl/pc_engine.sv
// Sequenced final computation: products, variance roots and the quotient on one 64-bit adder.
module pc_engine import pc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pc_ctrl_t ctrl,
    input  pc_sums_t sums,
    output pc_stat_t stat
);

    eng_state_t state_reg, state_next;
    mul_op_t    phase_reg, phase_next;
    logic       second_reg, second_next;
    logic       root_y_reg, root_y_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [ALU_W-1:0]   acc_reg, acc_next;
    logic [ALU_W-1:0]   mcand_reg, mcand_next;
    logic [MUL_B_W-1:0] mplier_reg, mplier_next;
    logic [ALU_W-1:0]   hold_reg, hold_next;
    logic [ALU_W-1:0]   num_reg, num_next;
    logic [ALU_W-1:0]   vx_reg, vx_next;
    logic [ALU_W-1:0]   vy_reg, vy_next;
    logic [ALU_W-1:0]   rval_reg, rval_next;
    logic [ALU_W-1:0]   rres_reg, rres_next;
    logic [ALU_W-1:0]   rbit_reg, rbit_next;
    logic [ROOT_W-1:0]  sx_reg, sx_next;
    logic [ALU_W-1:0]   d_reg, d_next;
    logic [ALU_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic               neg_reg, neg_next;
    logic               sat_reg, sat_next;
    logic               zero_reg, zero_next;

    // Shared adder; with sub set, the carry out means a >= b.
    logic [ALU_W-1:0] alu_a, alu_b;
    logic             alu_sub;
    logic [ALU_W:0]   alu_sum;
    logic             alu_carry;

    // Operand selection for the multiply sequence.
    mul_op_t              op_sel, phase_after;
    logic                 sec_sel;
    logic [ALU_W-1:0]     op_a;
    logic [MUL_B_W-1:0]   op_b;
    logic [SUM_EXT_W-1:0] sx_ext, sy_ext, sx_neg, sy_neg, abs_x, abs_y, x_signed;

    logic             var_zero;
    logic [QUO_W-1:0] rounded, mag_lim;

    localparam logic [ALU_W-1:0] ROOT_BIT_INIT = ALU_W'(1) << (ALU_W - 2);

    function automatic logic [ALU_W-1:0] root_arg(input logic [ALU_W-1:0] v);
        logic [ALU_W-1:0] lim;
        logic [ALU_W-1:0] u;
        lim = ALU_W'(1) << VAR_LIMIT_BIT;
        u   = (v > lim) ? lim : v;
        return u << ROOT_SHIFT;
    endfunction

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + {{ALU_W{1'b0}}, alu_sub};
    assign alu_carry = alu_sum[ALU_W];

    assign var_zero = vx_reg[ALU_W-1] || (vx_reg == '0) || vy_reg[ALU_W-1] || (vy_reg == '0);

    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = mcand_reg;
        alu_sub = 1'b0;
        case (state_reg)
            S_DIFF:
            begin
                alu_a   = hold_reg;
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            S_ROOT:
            begin
                alu_a   = rval_reg;
                alu_b   = rres_reg | rbit_reg;
                alu_sub = 1'b1;
            end
            S_ABS:
            begin
                alu_a   = '0;
                alu_b   = num_reg;
                alu_sub = 1'b1;
            end
            S_PRE:
            begin
                alu_a   = rem_reg;
                alu_b   = d_reg;
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = {rem_reg[ALU_W-2:0], 1'b0};
                alu_b   = d_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            MOP_NUM: phase_after = MOP_VX;
            default: phase_after = MOP_VY;
        endcase

        case (state_reg)
            S_START:
            begin
                op_sel  = MOP_NUM;
                sec_sel = 1'b0;
            end
            S_DIFF:
            begin
                op_sel  = phase_after;
                sec_sel = 1'b0;
            end
            default:
            begin
                op_sel  = phase_reg;
                sec_sel = 1'b1;
            end
        endcase

        sx_ext = {sums.sum_x[SUM_W-1], sums.sum_x};
        sy_ext = {sums.sum_y[SUM_W-1], sums.sum_y};
        sx_neg = '0 - sx_ext;
        sy_neg = '0 - sy_ext;
        abs_x  = sums.sum_x[SUM_W-1] ? sx_neg : sx_ext;
        abs_y  = sums.sum_y[SUM_W-1] ? sy_neg : sy_ext;
        // Sx*Sy is formed as (Sx with the sign of Sy folded in) times |Sy|.
        x_signed = sums.sum_y[SUM_W-1] ? sx_neg : sx_ext;

        op_a = '0;
        op_b = '0;
        case (op_sel)
            MOP_NUM:
            begin
                if (!sec_sel)
                begin
                    op_a = {{(ALU_W-SUM_XY_W){sums.sum_xy[SUM_XY_W-1]}}, sums.sum_xy};
                    op_b = {{(MUL_B_W-CNT_W){1'b0}}, sums.count};
                end
                else
                begin
                    op_a = {{(ALU_W-SUM_EXT_W){x_signed[SUM_EXT_W-1]}}, x_signed};
                    op_b = {{(MUL_B_W-SUM_EXT_W){1'b0}}, abs_y};
                end
            end
            MOP_VX:
            begin
                if (!sec_sel)
                begin
                    op_a = {{(ALU_W-SUM_SQ_W){1'b0}}, sums.sum_xx};
                    op_b = {{(MUL_B_W-CNT_W){1'b0}}, sums.count};
                end
                else
                begin
                    op_a = {{(ALU_W-SUM_EXT_W){1'b0}}, abs_x};
                    op_b = {{(MUL_B_W-SUM_EXT_W){1'b0}}, abs_x};
                end
            end
            MOP_VY:
            begin
                if (!sec_sel)
                begin
                    op_a = {{(ALU_W-SUM_SQ_W){1'b0}}, sums.sum_yy};
                    op_b = {{(MUL_B_W-CNT_W){1'b0}}, sums.count};
                end
                else
                begin
                    op_a = {{(ALU_W-SUM_EXT_W){1'b0}}, abs_y};
                    op_b = {{(MUL_B_W-SUM_EXT_W){1'b0}}, abs_y};
                end
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                    state_next = S_START;
            end
            S_START: state_next = S_MUL;
            S_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    if (phase_reg == MOP_DEN)
                        state_next = S_ABS;
                    else if (second_reg)
                        state_next = S_DIFF;
                end
            end
            S_DIFF:  state_next = (phase_reg == MOP_VY) ? S_CHECK : S_MUL;
            S_CHECK: state_next = var_zero ? S_DONE : S_ROOT;
            S_ROOT:
            begin
                if (rbit_reg == '0 && root_y_reg)
                    state_next = S_MUL;
            end
            S_ABS:   state_next = S_PRE;
            S_PRE:   state_next = alu_carry ? S_DONE : S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (ctrl.res_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        phase_next   = phase_reg;
        second_next  = second_reg;
        root_y_next  = root_y_reg;
        div_cnt_next = div_cnt_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        hold_next    = hold_reg;
        num_next     = num_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        rval_next    = rval_reg;
        rres_next    = rres_reg;
        rbit_next    = rbit_reg;
        sx_next      = sx_reg;
        d_next       = d_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        sat_next     = sat_reg;
        zero_next    = zero_reg;

        case (state_reg)
            S_START:
            begin
                phase_next  = MOP_NUM;
                second_next = 1'b0;
                acc_next    = '0;
                mcand_next  = op_a;
                mplier_next = op_b;
                zero_next   = 1'b0;
                sat_next    = 1'b0;
            end
            S_MUL:
            begin
                if (mplier_reg != '0)
                begin
                    if (mplier_reg[0])
                        acc_next = alu_sum[ALU_W-1:0];
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
                else if (phase_reg == MOP_DEN)
                    d_next = acc_reg;
                else if (!second_reg)
                begin
                    hold_next   = acc_reg;
                    acc_next    = '0;
                    mcand_next  = op_a;
                    mplier_next = op_b;
                    second_next = 1'b1;
                end
            end
            S_DIFF:
            begin
                case (phase_reg)
                    MOP_NUM: num_next = alu_sum[ALU_W-1:0];
                    MOP_VX:  vx_next  = alu_sum[ALU_W-1:0];
                    default: vy_next  = alu_sum[ALU_W-1:0];
                endcase
                if (phase_reg != MOP_VY)
                begin
                    phase_next  = phase_after;
                    second_next = 1'b0;
                    acc_next    = '0;
                    mcand_next  = op_a;
                    mplier_next = op_b;
                end
            end
            S_CHECK:
            begin
                zero_next   = var_zero;
                rval_next   = root_arg(vx_reg);
                rres_next   = '0;
                rbit_next   = ROOT_BIT_INIT;
                root_y_next = 1'b0;
            end
            S_ROOT:
            begin
                if (rbit_reg != '0)
                begin
                    if (alu_carry)
                    begin
                        rval_next = alu_sum[ALU_W-1:0];
                        rres_next = (rres_reg >> 1) | rbit_reg;
                    end
                    else
                        rres_next = rres_reg >> 1;
                    rbit_next = rbit_reg >> 2;
                end
                else if (!root_y_reg)
                begin
                    sx_next     = rres_reg[ROOT_W-1:0];
                    rval_next   = root_arg(vy_reg);
                    rres_next   = '0;
                    rbit_next   = ROOT_BIT_INIT;
                    root_y_next = 1'b1;
                end
                else
                begin
                    // Both roots are known: the denominator is their product.
                    phase_next  = MOP_DEN;
                    second_next = 1'b0;
                    acc_next    = '0;
                    mcand_next  = {{(ALU_W-ROOT_W){1'b0}}, sx_reg};
                    mplier_next = rres_reg[MUL_B_W-1:0];
                end
            end
            S_ABS:
            begin
                neg_next = num_reg[ALU_W-1];
                rem_next = (num_reg[ALU_W-1] ? alu_sum[ALU_W-1:0] : num_reg) << PRE_SHIFT;
            end
            S_PRE:
            begin
                // With the carry set, the quotient would not fit in QUO_W bits, so the result saturates.
                sat_next     = alu_carry;
                quo_next     = '0;
                div_cnt_next = '0;
            end
            S_DIV:
            begin
                if (alu_carry)
                begin
                    rem_next = alu_sum[ALU_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[ALU_W-2:0], 1'b0};
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        rounded = sat_reg ? ROUND_SAT : QUO_W'(({1'b0, quo_reg} + (QUO_W + 1)'(1)) >> 1);
        if (neg_reg)
            mag_lim = (rounded > NEG_MAX) ? NEG_MAX : rounded;
        else
            mag_lim = (rounded > POS_MAX) ? POS_MAX : rounded;

        stat.idle          = (state_reg == S_IDLE);
        stat.done          = (state_reg == S_DONE);
        stat.zero_variance = zero_reg;
        if (zero_reg)
            stat.correlation = '0;
        else if (neg_reg)
            stat.correlation = CORR_W'('0 - mag_lim);
        else
            stat.correlation = mag_lim[CORR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= MOP_NUM;
            second_reg  <= 1'b0;
            root_y_reg  <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            second_reg  <= second_next;
            root_y_reg  <= root_y_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        hold_reg   <= hold_next;
        num_reg    <= num_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        rval_reg   <= rval_next;
        rres_reg   <= rres_next;
        rbit_reg   <= rbit_next;
        sx_reg     <= sx_next;
        d_reg      <= d_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        sat_reg    <= sat_next;
        zero_reg   <= zero_next;
    end

    a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && ctrl.start) |=> (state_reg == S_START))
        else $error("engine did not leave idle on start");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && stat.zero_variance) |-> (stat.correlation == '0))
        else $error("zero variance result with nonzero correlation");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < d_reg))
        else $error("division remainder not below divisor");

endmodule

>>> dv/pearson_correlation_tb.sv
// Self-checking testbench of the Pearson correlation block: random-timed requests, scoreboarded results.
module pearson_correlation_tb;
    import pc_pkg::*;

    localparam int unsigned ITEM_TARGET  = 1450;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES  = 300;
    localparam int unsigned ROUND_STEPS  = 28;

    typedef enum int {
        SER_RANDOM,
        SER_TRACK,
        SER_MIRROR,
        SER_FLAT_X,
        SER_FLAT_Y,
        SER_EXTREME,
        SER_TINY
    } series_kind_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        logic                   last;
        logic                   drain;
    } pair_req_t;

    typedef struct packed {
        logic [CORR_W-1:0] correlation;
        logic              zero_variance;
        logic              too_many_samples;
        logic [CNT_W-1:0]  pair_count;
    } corr_result_t;

    logic clk;
    logic rst_n;

    pc_in_if  samples_if ();
    pc_out_if result_if ();

    pearson_correlation DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .result  (result_if)
    );

    pair_req_t    pair_queue[$];
    corr_result_t expected_results[$];
    pair_req_t    next_req;
    corr_result_t predicted;
    corr_result_t want;
    bit           produced;
    int           pushed;
    int           popped;

    int  total_items;
    int  sent_count;
    int  outstanding;
    int  error_count = 0;
    int  quiet_cycles;

    int  burst_left;
    int  gap_left;
    bit  drain_wait;
    int  stall_left;
    int  rx_cycles;

    // Running state of the predicted block.
    int     acc_count;
    longint acc_x;
    longint acc_y;
    longint acc_xy;
    longint acc_xx;
    longint acc_yy;
    bit     acc_overflow;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("tb: mismatch on %s: got %0d, expected %0d", what, got, exp_val);
        error_count++;
    endtask

    task automatic clear_sums();
        acc_count = 0;
        acc_x = 0;
        acc_y = 0;
        acc_xy = 0;
        acc_xx = 0;
        acc_yy = 0;
        acc_overflow = 1'b0;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned probe;
        res = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= res + probe)
            begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    // Root of a variance term with six fraction bits; huge terms are clamped first.
    function automatic longint unsigned variance_root(input longint v);
        longint unsigned u;
        if (v <= 0)
            return 0;
        u = v;
        if (u > (64'd1 << VAR_LIMIT_BIT))
            u = 64'd1 << VAR_LIMIT_BIT;
        return int_sqrt(u << ROOT_SHIFT);
    endfunction

    function automatic corr_result_t finish_series();
        corr_result_t    r;
        longint          n;
        longint          num;
        longint          vx;
        longint          vy;
        longint unsigned d;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned rounded;
        bit              neg;
        n = acc_count;
        num = n * acc_xy - acc_x * acc_y;
        vx = n * acc_xx - acc_x * acc_x;
        vy = n * acc_yy - acc_y * acc_y;
        r.zero_variance = 1'b0;
        r.correlation = '0;
        if (vx <= 0 || vy <= 0)
            r.zero_variance = 1'b1;
        else
        begin
            d = variance_root(vx) * variance_root(vy);
            if (d == 0)
                d = 1;
            neg = (num < 0);
            mag = neg ? longint'(-num) : longint'(num);
            q = mag / d;
            rem = mag % d;
            if (q >= 2)
                rounded = 65536;
            else
            begin
                for (int i = 0; i < ROUND_STEPS; i++)
                begin
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= d)
                    begin
                        rem = rem - d;
                        q = q | 1;
                    end
                end
                rounded = (q + 1) >> 1;
            end
            if (neg)
            begin
                if (rounded > NEG_MAX)
                    rounded = NEG_MAX;
                r.correlation = CORR_W'(-rounded);
            end
            else
            begin
                if (rounded > POS_MAX)
                    rounded = POS_MAX;
                r.correlation = CORR_W'(rounded);
            end
        end
        r.too_many_samples = acc_overflow;
        r.pair_count = CNT_W'(acc_count);
        return r;
    endfunction

    task automatic accumulate_pair(input logic signed [SAMPLE_BITS-1:0] xs,
                                   input logic signed [SAMPLE_BITS-1:0] ys,
                                   input logic last, output bit has_result,
                                   output corr_result_t res);
        longint xv;
        longint yv;
        xv = xs;
        yv = ys;
        has_result = 1'b0;
        res = '0;
        if (acc_count >= MAX_SAMPLES)
            acc_overflow = 1'b1;
        else
        begin
            acc_count++;
            acc_x += xv;
            acc_y += yv;
            acc_xy += xv * yv;
            acc_xx += xv * xv;
            acc_yy += yv * yv;
        end
        if (last)
        begin
            res = finish_series();
            has_result = 1'b1;
            clear_sums();
        end
    endtask

    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return SAMPLE_BITS'(v);
    endfunction

    task automatic add_pair(input int x, input int y, input bit last, input bit drain);
        pair_req_t r;
        r.x = sat_sample(x);
        r.y = sat_sample(y);
        r.last = last;
        r.drain = drain;
        pair_queue = {pair_queue, r};
    endtask

    function automatic int full_sample();
        return int'($urandom_range(65535, 0)) - 32768;
    endfunction

    function automatic int extreme_sample();
        case ($urandom_range(3, 0))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    task automatic add_series(input int len, input series_kind_t kind, input bit drain);
        int base;
        int xv;
        int yv;
        int noise;
        base = full_sample();
        for (int i = 0; i < len; i++)
        begin
            noise = int'($urandom_range(2000, 0)) - 1000;
            xv = full_sample();
            yv = full_sample();
            case (kind)
                SER_TRACK:   yv = xv + noise;
                SER_MIRROR:  yv = -xv - 1 + noise;
                SER_FLAT_X:  xv = base;
                SER_FLAT_Y:  yv = base;
                SER_EXTREME:
                begin
                    xv = extreme_sample();
                    yv = extreme_sample();
                end
                SER_TINY:
                begin
                    xv = int'($urandom_range(8, 0)) - 4;
                    yv = int'($urandom_range(8, 0)) - 4;
                end
                default: ;
            endcase
            add_pair(xv, yv, i == len - 1, drain && i == 0);
        end
    endtask

    // Sender: bursts of requests separated by random gaps, with an occasional drain.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_if.valid <= 1'b0;
            samples_if.x_sample <= '0;
            samples_if.y_sample <= '0;
            samples_if.last_pair <= 1'b0;
            sent_count <= 0;
            burst_left <= 4;
            gap_left <= 0;
            drain_wait <= 1'b0;
        end
        else
        begin
            if (samples_if.valid && samples_if.ready)
                sent_count <= sent_count + 1;
            if (!samples_if.valid || samples_if.ready)
            begin
                if (gap_left != 0)
                begin
                    samples_if.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pair_queue.size() == 0)
                    samples_if.valid <= 1'b0;
                else if (pair_queue[0].drain && (!drain_wait || outstanding != 0))
                begin
                    // Hold the request back until every result in flight has come out.
                    samples_if.valid <= 1'b0;
                    drain_wait <= 1'b1;
                end
                else
                begin
                    next_req = pair_queue.pop_front();
                    samples_if.valid <= 1'b1;
                    samples_if.x_sample <= next_req.x;
                    samples_if.y_sample <= next_req.y;
                    samples_if.last_pair <= next_req.last;
                    drain_wait <= 1'b0;
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30)
                                                                  : $urandom_range(20, 1);
                        if ($urandom_range(3, 0) == 0)
                            gap_left <= 0;
                        else if ($urandom_range(9, 0) == 0)
                            gap_left <= $urandom_range(30, 10);
                        else
                            gap_left <= $urandom_range(4, 1);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: the stall pattern follows bits 9:8 of a free-running cycle counter.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_left <= 0;
            rx_cycles <= 0;
        end
        else
        begin
            rx_cycles <= rx_cycles + 1;
            if (stall_left != 0)
            begin
                result_if.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                result_if.ready <= 1'b1;
                case (rx_cycles[9:8])
                    2'd0: ;
                    2'd2:
                        if ($urandom_range(7, 0) == 0)
                            stall_left <= $urandom_range(40, 5);
                    default:
                        if ($urandom_range(2, 0) == 0)
                            stall_left <= $urandom_range(3, 1);
                endcase
            end
        end
    end

    // Monitor: predict on every accepted request, check every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sums();
            outstanding <= 0;
        end
        else
        begin
            pushed = 0;
            popped = 0;
            if (samples_if.valid && samples_if.ready)
            begin
                accumulate_pair(samples_if.x_sample, samples_if.y_sample,
                                samples_if.last_pair, produced, predicted);
                if (produced)
                begin
                    expected_results = {expected_results, predicted};
                    pushed = 1;
                end
            end
            if (result_if.valid && result_if.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, correlation",
                                    longint'(result_if.correlation), 0);
                else
                begin
                    want = expected_results.pop_front();
                    popped = 1;
                    if (result_if.correlation !== want.correlation)
                        report_mismatch("correlation", longint'(result_if.correlation),
                                        longint'($signed(want.correlation)));
                    if (result_if.zero_variance !== want.zero_variance)
                        report_mismatch("zero_variance", longint'(result_if.zero_variance),
                                        longint'(want.zero_variance));
                    if (result_if.too_many_samples !== want.too_many_samples)
                        report_mismatch("too_many_samples",
                                        longint'(result_if.too_many_samples),
                                        longint'(want.too_many_samples));
                    if (result_if.pair_count !== want.pair_count)
                        report_mismatch("pair_count", longint'(result_if.pair_count),
                                        longint'(want.pair_count));
                end
            end
            outstanding <= outstanding + pushed - popped;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples_if.valid && samples_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        else
            quiet_cycles <= 0;
    end

    initial begin
        rst_n = 1'b0;

        // A single pair has no variance.
        add_pair(0, 0, 1, 0);
        // Extremes rising together, then against each other.
        add_pair(32767, 32767, 0, 0);
        add_pair(-32768, -32768, 1, 0);
        add_pair(32767, -32768, 0, 1);
        add_pair(-32768, 32767, 1, 0);
        // Constant x, then a wide x against a nearly flat y.
        add_pair(5, 100, 0, 0);
        add_pair(5, -7, 0, 0);
        add_pair(5, 3, 1, 0);
        add_pair(-32768, 9, 0, 0);
        add_pair(1200, -1, 0, 0);
        add_pair(-5, -1, 1, 0);
        // Small mixed series and an all-extremes series.
        add_pair(1, -1, 0, 0);
        add_pair(2, 3, 0, 0);
        add_pair(3, 2, 0, 0);
        add_pair(-4, -1, 1, 0);
        add_pair(-32768, 0, 0, 0);
        add_pair(0, 32767, 0, 0);
        add_pair(32767, -1, 0, 0);
        add_pair(-1, -32768, 1, 0);

        // One pair more than the block can count; the final one is dropped.
        add_series(MAX_SAMPLES + 1, SER_TRACK, 1'b1);

        while (pair_queue.size() < ITEM_TARGET)
            add_series(($urandom_range(11, 0) == 0) ? $urandom_range(48, 13)
                                                    : $urandom_range(12, 1),
                       series_kind_t'($urandom_range(6, 0)),
                       $urandom_range(19, 0) == 0);
        total_items = pair_queue.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count != total_items)
            @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/pc_pkg.sv
rtl/pc_if.sv
rtl/pc_engine.sv
rtl/pearson_correlation.sv
dv/pearson_correlation_tb.sv
